// ===== hdl/waiir_pkg.sv =====
// ----------------------------------------------------------------------------
// waiir_pkg
// Shared types, constants and the microcode program of the Wood-Anderson
// recursive filter.
// ----------------------------------------------------------------------------
package waiir_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int ACCUM_WIDTH_DEF  = 48;

  localparam int COEF_W    = 32;
  localparam int LIMB_W    = 32;
  localparam int SHIFT_W   = 6;
  localparam int CFG_IDX_W = 3;
  localparam int POLE_W    = 31;
  localparam int PC_W      = 6;

  localparam logic [SHIFT_W-1:0] COEF_FRAC = 6'd30;
  localparam logic [COEF_W-1:0]  GAIN_FIX  = 32'd797636784;

  // Register reset values
  localparam logic [COEF_W-1:0]  RST_SCALE = 32'd2147483648;
  localparam logic [SHIFT_W-1:0] RST_SHIFT = 6'd31;
  localparam logic [COEF_W-1:0]  RST_WG    = 32'd318837000;
  localparam logic [COEF_W-1:0]  RST_FB    = 32'd2283560648;
  localparam logic [COEF_W-1:0]  RST_INVD  = 32'd947707000;
  localparam logic [POLE_W-1:0]  RST_POLE  = 31'd1071594340;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_MODE   = 3'd0,
    REG_INPUT_SCALE  = 3'd1,
    REG_INPUT_SHIFT  = 3'd2,
    REG_WA_GAIN_DT2  = 3'd3,
    REG_FEEDBACK     = 3'd4,
    REG_INV_DENOM    = 3'd5,
    REG_HP_POLE      = 3'd6,
    REG_GAIN_CORR    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                mode;
    logic [COEF_W-1:0]   scale;
    logic [SHIFT_W-1:0]  shift;
    logic [COEF_W-1:0]   wg;
    logic [COEF_W-1:0]   fb;
    logic [COEF_W-1:0]   invd;
    logic [POLE_W-1:0]   pole;
    logic                gain;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_LOAD  = 4'd1,
    OP_MLO   = 4'd2,
    OP_MHI   = 4'd3,
    OP_MFIN  = 4'd4,
    OP_ADD   = 4'd5,
    OP_SAVEA = 4'd6,
    OP_HIST  = 4'd7,
    OP_HISTZ = 4'd8,
    OP_EMIT  = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    SRC_DIFF = 3'd0,
    SRC_Y1   = 3'd1,
    SRC_ACC  = 3'd2,
    SRC_A1   = 3'd3,
    SRC_M    = 3'd4
  } src_t;

  typedef enum logic [2:0] {
    CF_SCALE = 3'd0,
    CF_FB    = 3'd1,
    CF_INVD  = 3'd2,
    CF_POLE  = 3'd3,
    CF_WG    = 3'd4,
    CF_GAIN  = 3'd5
  } coef_t;

  typedef enum logic {
    SH_REG  = 1'b0,
    SH_FRAC = 1'b1
  } sh_t;

  typedef enum logic {
    ADDA_ZERO = 1'b0,
    ADDA_ACC  = 1'b1
  } adda_t;

  typedef enum logic [1:0] {
    ADDB_ZERO  = 2'd0,
    ADDB_M     = 2'd1,
    ADDB_NEGY2 = 2'd2
  } addb_t;

  typedef enum logic [2:0] {
    JC_NEVER    = 3'd0,
    JC_ALWAYS   = 3'd1,
    JC_MODE     = 3'd2,
    JC_SEEN0    = 3'd3,
    JC_SEEN_GE2 = 3'd4,
    JC_NOGAIN   = 3'd5
  } jc_t;

  typedef struct packed {
    op_t              op;
    src_t             src;
    coef_t            coef;
    sh_t              sh;
    adda_t            add_a;
    addb_t            add_b;
    jc_t              jcond;
    logic [PC_W-1:0]  target;
  } uc_word_t;

  typedef struct packed {
    logic      accept;
    logic      exec;
    uc_word_t  uc;
  } dp_ctl_t;

  typedef struct packed {
    logic seen_zero;
    logic seen_two;
  } dp_stat_t;

  // Program labels
  localparam logic [PC_W-1:0] PC_VREC   = 6'd5;
  localparam logic [PC_W-1:0] PC_OUT    = 6'd16;
  localparam logic [PC_W-1:0] PC_EMIT   = 6'd21;
  localparam logic [PC_W-1:0] PC_ACCEL  = 6'd22;
  localparam logic [PC_W-1:0] PC_ZERO_A = 6'd28;
  localparam logic [PC_W-1:0] PC_SAVE_A = 6'd29;
  localparam logic [PC_W-1:0] PC_START  = 6'd0;
  localparam logic [PC_W-1:0] PROG_LEN  = 6'd36;

  function automatic uc_word_t uc_w(op_t op, src_t src, coef_t cf, sh_t sh,
                                    adda_t a, addb_t b, jc_t jc,
                                    logic [PC_W-1:0] tgt);
    uc_word_t w;
    w.op     = op;
    w.src    = src;
    w.coef   = cf;
    w.sh     = sh;
    w.add_a  = a;
    w.add_b  = b;
    w.jcond  = jc;
    w.target = tgt;
    return w;
  endfunction

  // Filter program: a multiply takes LOAD, MLO, MHI, MFIN.
  function automatic uc_word_t uc_rom(logic [PC_W-1:0] pc);
    uc_word_t w;
    w = uc_w(OP_NOP, SRC_DIFF, CF_SCALE, SH_FRAC, ADDA_ZERO, ADDB_ZERO, JC_NEVER, PC_START);
    unique case (pc)
      // scaled first difference u
      6'd0:  w = uc_w(OP_LOAD, SRC_DIFF, CF_SCALE, SH_REG, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd1:  w = uc_w(OP_MLO, SRC_DIFF, CF_SCALE, SH_REG, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd2:  w = uc_w(OP_MHI, SRC_DIFF, CF_SCALE, SH_REG, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd3:  w = uc_w(OP_MFIN, SRC_DIFF, CF_SCALE, SH_REG, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd4:  w = uc_w(OP_ADD, SRC_DIFF, CF_SCALE, SH_REG, ADDA_ZERO, ADDB_M,
                      JC_MODE, PC_ACCEL);
      // recursion: acc = drive + fb*y1 - y2, y = invd*acc
      6'd5:  w = uc_w(OP_LOAD, SRC_Y1, CF_FB, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd6:  w = uc_w(OP_MLO, SRC_Y1, CF_FB, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd7:  w = uc_w(OP_MHI, SRC_Y1, CF_FB, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd8:  w = uc_w(OP_MFIN, SRC_Y1, CF_FB, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd9:  w = uc_w(OP_ADD, SRC_Y1, CF_FB, SH_FRAC, ADDA_ACC, ADDB_M,
                      JC_NEVER, PC_START);
      6'd10: w = uc_w(OP_ADD, SRC_Y1, CF_FB, SH_FRAC, ADDA_ACC, ADDB_NEGY2,
                      JC_NEVER, PC_START);
      6'd11: w = uc_w(OP_LOAD, SRC_ACC, CF_INVD, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd12: w = uc_w(OP_MLO, SRC_ACC, CF_INVD, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd13: w = uc_w(OP_MHI, SRC_ACC, CF_INVD, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd14: w = uc_w(OP_MFIN, SRC_ACC, CF_INVD, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd15: w = uc_w(OP_HIST, SRC_ACC, CF_INVD, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      // optional gain correction
      6'd16: w = uc_w(OP_NOP, SRC_M, CF_GAIN, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NOGAIN, PC_EMIT);
      6'd17: w = uc_w(OP_LOAD, SRC_M, CF_GAIN, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd18: w = uc_w(OP_MLO, SRC_M, CF_GAIN, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd19: w = uc_w(OP_MHI, SRC_M, CF_GAIN, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd20: w = uc_w(OP_MFIN, SRC_M, CF_GAIN, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd21: w = uc_w(OP_EMIT, SRC_M, CF_GAIN, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      // acceleration: a = u + pole*a1, forced to zero on the first sample
      6'd22: w = uc_w(OP_NOP, SRC_A1, CF_POLE, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_SEEN0, PC_ZERO_A);
      6'd23: w = uc_w(OP_LOAD, SRC_A1, CF_POLE, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd24: w = uc_w(OP_MLO, SRC_A1, CF_POLE, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd25: w = uc_w(OP_MHI, SRC_A1, CF_POLE, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd26: w = uc_w(OP_MFIN, SRC_A1, CF_POLE, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd27: w = uc_w(OP_ADD, SRC_A1, CF_POLE, SH_FRAC, ADDA_ACC, ADDB_M,
                      JC_ALWAYS, PC_SAVE_A);
      6'd28: w = uc_w(OP_ADD, SRC_A1, CF_POLE, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd29: w = uc_w(OP_SAVEA, SRC_ACC, CF_WG, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd30: w = uc_w(OP_LOAD, SRC_ACC, CF_WG, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd31: w = uc_w(OP_MLO, SRC_ACC, CF_WG, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd32: w = uc_w(OP_MHI, SRC_ACC, CF_WG, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd33: w = uc_w(OP_MFIN, SRC_ACC, CF_WG, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_NEVER, PC_START);
      6'd34: w = uc_w(OP_ADD, SRC_ACC, CF_WG, SH_FRAC, ADDA_ZERO, ADDB_M,
                      JC_SEEN_GE2, PC_VREC);
      6'd35: w = uc_w(OP_HISTZ, SRC_M, CF_GAIN, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                      JC_ALWAYS, PC_OUT);
      default: w = uc_w(OP_NOP, SRC_DIFF, CF_SCALE, SH_FRAC, ADDA_ZERO, ADDB_ZERO,
                        JC_NEVER, PC_START);
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/waiir_in_if.sv =====
// ----------------------------------------------------------------------------
// waiir_in_if
// Sample input channel: valid/ready with sample and trace start mark.
// ----------------------------------------------------------------------------
interface waiir_in_if
  import waiir_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           trace_start;

  modport source (output valid, output sample, output trace_start, input ready);
  modport sink   (input valid, input sample, input trace_start, output ready);
endinterface

// ===== hdl/waiir_out_if.sv =====
// ----------------------------------------------------------------------------
// waiir_out_if
// Result channel: valid/ready with filtered sample and clip flag.
// ----------------------------------------------------------------------------
interface waiir_out_if
  import waiir_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered;
  logic                           saturated;

  modport source (output valid, output filtered, output saturated, input ready);
  modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

// ===== hdl/waiir_cfg_if.sv =====
// ----------------------------------------------------------------------------
// waiir_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface waiir_cfg_if
  import waiir_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/waiir_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// waiir_cfg_regs
// Coefficient and mode registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module waiir_cfg_regs
  import waiir_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [COEF_W-1:0]    wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign wr_ready = rst_n;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_valid) begin
      unique case (cfg_reg_t'(wr_index))
        REG_INPUT_MODE:  cfg_nxt.mode  = wr_data[0];
        REG_INPUT_SCALE: cfg_nxt.scale = wr_data;
        REG_INPUT_SHIFT: cfg_nxt.shift = wr_data[SHIFT_W-1:0];
        REG_WA_GAIN_DT2: cfg_nxt.wg    = wr_data;
        REG_FEEDBACK:    cfg_nxt.fb    = wr_data;
        REG_INV_DENOM:   cfg_nxt.invd  = wr_data;
        REG_HP_POLE:     cfg_nxt.pole  = wr_data[POLE_W-1:0];
        REG_GAIN_CORR:   cfg_nxt.gain  = wr_data[0];
        default:         cfg_nxt       = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= 1'b0;
      cfg_r.scale <= RST_SCALE;
      cfg_r.shift <= RST_SHIFT;
      cfg_r.wg    <= RST_WG;
      cfg_r.fb    <= RST_FB;
      cfg_r.invd  <= RST_INVD;
      cfg_r.pole  <= RST_POLE;
      cfg_r.gain  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hdl/waiir_seq.sv =====
// ----------------------------------------------------------------------------
// waiir_seq
// Microcode sequencer: step counter, program ROM, conditional jumps and the
// input/output handshakes.
// ----------------------------------------------------------------------------
module waiir_seq
  import waiir_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  cfg_t     cfg,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl
);

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            out_valid_r, out_valid_nxt;
  uc_word_t        uc;
  logic            jump;
  logic            stall;
  logic            exec;
  logic            in_fire;
  logic            emit;

  assign uc       = uc_rom(pc_r);
  assign in_ready = rst_n && !busy_r;
  assign in_fire  = in_valid && in_ready;
  // hold the emit step while the previous result is still unclaimed
  assign stall    = (uc.op == OP_EMIT) && out_valid_r && !out_ready;
  assign exec     = busy_r && !stall;
  assign emit     = exec && (uc.op == OP_EMIT);
  assign out_valid = out_valid_r;

  assign ctl.accept = in_fire;
  assign ctl.exec   = exec;
  assign ctl.uc     = uc;

  always_comb begin
    unique case (uc.jcond)
      JC_NEVER:    jump = 1'b0;
      JC_ALWAYS:   jump = 1'b1;
      JC_MODE:     jump = cfg.mode;
      JC_SEEN0:    jump = stat.seen_zero;
      JC_SEEN_GE2: jump = stat.seen_two;
      JC_NOGAIN:   jump = !cfg.gain;
      default:     jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
      pc_nxt   = PC_START;
    end else if (emit) begin
      busy_nxt = 1'b0;
      pc_nxt   = PC_START;
    end else if (exec) begin
      pc_nxt = jump ? uc.target : pc_r + 1'b1;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_START;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (busy_r && pc_r == PC_START))
    else $error("accepted sample did not start the program");

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r < PROG_LEN))
    else $error("step counter left the program");

  a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && !busy_r))
    else $error("emit step did not present a result");

endmodule

// ===== hdl/waiir_datapath.sv =====
// ----------------------------------------------------------------------------
// waiir_datapath
// Filter history, shared 32x32 multiplier with shift and saturation, the
// saturating adder and the output clipper, one control word per exec cycle.
// ----------------------------------------------------------------------------
module waiir_datapath
  import waiir_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int ACCUM_WIDTH  = ACCUM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           trace_start,
  input  cfg_t                           cfg,
  input  dp_ctl_t                        ctl,
  output dp_stat_t                       stat,
  output logic signed [SAMPLE_WIDTH-1:0] filtered,
  output logic                           saturated
);

  localparam int MAG_W0 = (SAMPLE_WIDTH + 1 > ACCUM_WIDTH) ? SAMPLE_WIDTH + 1 : ACCUM_WIDTH;
  localparam int MAG_W  = (MAG_W0 < LIMB_W + 1) ? LIMB_W + 1 : MAG_W0;
  localparam int HI_W   = MAG_W - LIMB_W;
  localparam int PROD_W = MAG_W + COEF_W;
  localparam int EXT_W  = (ACCUM_WIDTH > SAMPLE_WIDTH) ? ACCUM_WIDTH : SAMPLE_WIDTH;

  localparam logic signed [ACCUM_WIDTH-1:0] ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
  localparam logic signed [ACCUM_WIDTH-1:0] ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] x_r, prev_r;
  logic signed [ACCUM_WIDTH-1:0]  y1_r, y2_r, a1_r, acc_r, m_r;
  logic [1:0]                     seen_r;
  logic [MAG_W-1:0]               mag_r;
  logic                           neg_r;
  logic [PROD_W-1:0]              prod_r;
  logic signed [SAMPLE_WIDTH-1:0] out_data_r;
  logic                           out_clip_r;

  logic signed [SAMPLE_WIDTH:0]   diff;
  logic signed [MAG_W:0]          ld_val;
  logic [MAG_W-1:0]               ld_mag;
  logic [COEF_W-1:0]              coef;
  logic [2*LIMB_W-1:0]            pp_lo;
  logic [HI_W+COEF_W-1:0]         pp_hi;
  logic [SHIFT_W-1:0]             shamt;
  logic [PROD_W-1:0]              sh_val;
  logic                           fin_ovf;
  logic signed [ACCUM_WIDTH-1:0]  fin_mag;
  logic signed [ACCUM_WIDTH-1:0]  fin_val;
  logic signed [ACCUM_WIDTH-1:0]  neg_y2;
  logic signed [ACCUM_WIDTH-1:0]  add_a;
  logic signed [ACCUM_WIDTH-1:0]  add_b;
  logic signed [ACCUM_WIDTH:0]    add_sum;
  logic signed [ACCUM_WIDTH-1:0]  add_val;
  logic signed [EXT_W-1:0]        m_ext;
  logic                           clip_hi, clip_lo;
  logic signed [SAMPLE_WIDTH-1:0] clip_val;
  logic [1:0]                     seen_inc;

  assign stat.seen_zero = (seen_r == 2'd0);
  assign stat.seen_two  = seen_r[1];
  assign filtered       = out_data_r;
  assign saturated      = out_clip_r;

  assign diff = (SAMPLE_WIDTH+1)'(x_r) - (SAMPLE_WIDTH+1)'(prev_r);

  // operand magnitude and sign for the multiplier
  always_comb begin
    case (ctl.uc.src)
      SRC_DIFF: ld_val = (MAG_W+1)'(diff);
      SRC_Y1:   ld_val = (MAG_W+1)'(y1_r);
      SRC_ACC:  ld_val = (MAG_W+1)'(acc_r);
      SRC_A1:   ld_val = (MAG_W+1)'(a1_r);
      SRC_M:    ld_val = (MAG_W+1)'(m_r);
      default:  ld_val = '0;
    endcase
    ld_mag = ld_val[MAG_W] ? (MAG_W)'(-ld_val) : ld_val[MAG_W-1:0];
  end

  always_comb begin
    case (ctl.uc.coef)
      CF_SCALE: coef = cfg.scale;
      CF_FB:    coef = cfg.fb;
      CF_INVD:  coef = cfg.invd;
      CF_POLE:  coef = (COEF_W)'(cfg.pole);
      CF_WG:    coef = cfg.wg;
      CF_GAIN:  coef = GAIN_FIX;
      default:  coef = '0;
    endcase
  end

  assign pp_lo = (2*LIMB_W)'(mag_r[LIMB_W-1:0]) * (2*LIMB_W)'(coef);
  assign pp_hi = (HI_W+COEF_W)'(mag_r[MAG_W-1:LIMB_W]) * (HI_W+COEF_W)'(coef);

  // shift, clamp to the accumulator range, restore the sign
  always_comb begin
    shamt   = (ctl.uc.sh == SH_FRAC) ? COEF_FRAC : cfg.shift;
    sh_val  = prod_r >> shamt;
    fin_ovf = |sh_val[PROD_W-1:ACCUM_WIDTH-1];
    fin_mag = {1'b0, sh_val[ACCUM_WIDTH-2:0]};
    if (fin_ovf) begin
      fin_val = neg_r ? ACC_MIN : ACC_MAX;
    end else begin
      fin_val = neg_r ? -fin_mag : fin_mag;
    end
  end

  always_comb begin
    neg_y2 = (y2_r == ACC_MIN) ? ACC_MAX : -y2_r;
    add_a  = (ctl.uc.add_a == ADDA_ACC) ? acc_r : '0;
    case (ctl.uc.add_b)
      ADDB_M:     add_b = m_r;
      ADDB_NEGY2: add_b = neg_y2;
      default:    add_b = '0;
    endcase
    add_sum = (ACCUM_WIDTH+1)'(add_a) + (ACCUM_WIDTH+1)'(add_b);
    if (add_sum[ACCUM_WIDTH] != add_sum[ACCUM_WIDTH-1]) begin
      add_val = add_sum[ACCUM_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      add_val = add_sum[ACCUM_WIDTH-1:0];
    end
  end

  // clip the result to the sample range
  always_comb begin
    m_ext   = (EXT_W)'(m_r);
    clip_hi = m_ext > (EXT_W)'(SMP_MAX);
    clip_lo = m_ext < (EXT_W)'(SMP_MIN);
    if (clip_hi) begin
      clip_val = SMP_MAX;
    end else if (clip_lo) begin
      clip_val = SMP_MIN;
    end else begin
      clip_val = m_ext[SAMPLE_WIDTH-1:0];
    end
    seen_inc = seen_r[1] ? seen_r : seen_r + 2'd1;
  end

  // history and control-relevant state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      y1_r   <= '0;
      y2_r   <= '0;
      a1_r   <= '0;
      seen_r <= 2'd0;
    end else if (ctl.accept) begin
      if (trace_start) begin
        prev_r <= '0;
        y1_r   <= '0;
        y2_r   <= '0;
        a1_r   <= '0;
        seen_r <= 2'd0;
      end
    end else if (ctl.exec) begin
      case (ctl.uc.op)
        OP_LOAD: begin
          if (ctl.uc.src == SRC_DIFF) begin
            prev_r <= x_r;
          end
        end
        OP_SAVEA: a1_r <= acc_r;
        OP_HIST: begin
          y2_r   <= y1_r;
          y1_r   <= m_r;
          seen_r <= seen_inc;
        end
        OP_HISTZ: begin
          y2_r   <= y1_r;
          y1_r   <= '0;
          seen_r <= seen_inc;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      x_r <= sample;
    end
    if (ctl.exec) begin
      case (ctl.uc.op)
        OP_LOAD: begin
          mag_r <= ld_mag;
          neg_r <= ld_val[MAG_W];
        end
        OP_MLO:  prod_r <= (PROD_W)'(pp_lo);
        OP_MHI:  prod_r <= prod_r + ((PROD_W)'(pp_hi) << LIMB_W);
        OP_MFIN: m_r <= fin_val;
        OP_ADD:  acc_r <= add_val;
        OP_HISTZ: m_r <= '0;
        OP_EMIT: begin
          out_data_r <= clip_val;
          out_clip_r <= clip_hi || clip_lo;
        end
        default: ;
      endcase
    end
  end

  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r != 2'd3)
    else $error("sample count ran past two");

  a_histz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && !ctl.accept && ctl.uc.op == OP_HISTZ) |=> (m_r == '0 && y1_r == '0))
    else $error("warm-up step left a nonzero output");

endmodule

// ===== hdl/wood_anderson_iir_filter.sv =====
// ----------------------------------------------------------------------------
// wood_anderson_iir_filter
// Wood-Anderson two-pole recursive filter for Q16.16 seismometer samples.
//
// One sample is taken at a time. After the accepting edge a microcode
// program runs on one shared 32x32 multiplier, each multiply taking four
// steps (operand load, low partial product, high partial product, shift and
// clamp). In velocity mode every sample runs the recursion. In acceleration
// mode the first sample of a trace forces the acceleration to zero, and the
// first two samples of a trace put out zero without the recursion; the gain
// correction, when on, adds one multiply. A new sample is taken once the
// previous result has been placed in the output register, even if that
// result has not yet been claimed; the final step of the next sample then
// waits until that earlier result is claimed. The configuration channel is
// ready whenever the block is out of reset; write it only while no sample is
// in flight. Set trace_start on the first sample of each trace to clear the
// history; reset leaves the block as at a trace start.
// ----------------------------------------------------------------------------
module wood_anderson_iir_filter
  import waiir_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int ACCUM_WIDTH  = ACCUM_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  waiir_in_if.sink    in_if,
  waiir_out_if.source out_if,
  waiir_cfg_if.sink   cfg_if
);

  cfg_t     cfg;
  dp_ctl_t  ctl;
  dp_stat_t stat;

  waiir_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_if.valid),
    .wr_ready (cfg_if.ready),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .cfg      (cfg)
  );

  waiir_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cfg       (cfg),
    .stat      (stat),
    .ctl       (ctl)
  );

  waiir_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACCUM_WIDTH  (ACCUM_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample      (in_if.sample),
    .trace_start (in_if.trace_start),
    .cfg         (cfg),
    .ctl         (ctl),
    .stat        (stat),
    .filtered    (out_if.filtered),
    .saturated   (out_if.saturated)
  );

endmodule
